FILE: src/qpid_pkg.sv
// Package for the quadrature PID position controller.
// Holds field widths, opcodes, register indexes, reset values, the sequencer states
// and the structs shared by the modules. No dependencies.
package qpid_pkg;

    localparam int OPC_W      = 2;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COEF_W     = 10;
    localparam int PERIOD_W   = 8;
    localparam int SCALE_W    = 16;
    localparam int TARGET_W   = 16;
    localparam int ELAPSED_W  = 16;
    localparam int DUTY_W     = 10;
    localparam int POS_W      = 24;
    localparam int ITAE_W     = 48;
    localparam int ERR_W      = 32;
    localparam int DRIVE_W    = 48;
    localparam int ACC_W      = 52;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 25;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int EP_W       = ELAPSED_W + PERIOD_W;
    localparam int ADD_W      = ITAE_W + PERIOD_W;

    localparam logic [COEF_W-1:0]   RST_COEF_NOW   = 10'd130;
    localparam logic [COEF_W-1:0]   RST_COEF_PREV  = 10'd80;
    localparam logic [COEF_W-1:0]   RST_COEF_PREV2 = 10'd0;
    localparam logic [DUTY_W-1:0]   RST_PWM_RANGE  = 10'd100;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 8'd5;
    localparam logic [SCALE_W-1:0]  RST_GEAR_SCALE = 16'd303;

    typedef enum logic [OPC_W-1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_TICK   = 2'd2,
        OP_START  = 2'd3
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_NOW   = 3'd0,
        REG_COEF_PREV  = 3'd1,
        REG_COEF_PREV2 = 3'd2,
        REG_PWM_RANGE  = 3'd3,
        REG_PERIOD     = 3'd4,
        REG_GEAR_SCALE = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_POS,
        S_ERR,
        S_MUL_NOW,
        S_MUL_PREV,
        S_MUL_PREV2,
        S_MUL_EP,
        S_DRIVE,
        S_MUL_ITAE,
        S_ITAE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COEF_W-1:0]   coef_now;
        logic [COEF_W-1:0]   coef_prev;
        logic [COEF_W-1:0]   coef_prev2;
        logic [DUTY_W-1:0]   pwm_range;
        logic [PERIOD_W-1:0] loop_period;
        logic [SCALE_W-1:0]  gear_scale;
    } t_cfg;

    typedef struct packed {
        logic en;
        logic sel_b;
        logic chan_a;
        logic chan_b;
    } t_edge;

endpackage

FILE: src/qpid_if.sv
// Valid/ready channel interfaces: configuration writes, input items and results.
// Depends on qpid_pkg.
interface qpid_cfg_if import qpid_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface qpid_in_if import qpid_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OPC_W-1:0]            opcode;
    logic                        chan_a;
    logic                        chan_b;
    logic signed [TARGET_W-1:0]  target_position;
    logic [ELAPSED_W-1:0]        elapsed_ms;

    modport source (output valid, output opcode, output chan_a, output chan_b,
                    output target_position, output elapsed_ms, input ready);
    modport sink   (input valid, input opcode, input chan_a, input chan_b,
                    input target_position, input elapsed_ms, output ready);
endinterface

interface qpid_out_if import qpid_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [DUTY_W-1:0]        forward_duty;
    logic [DUTY_W-1:0]        reverse_duty;
    logic signed [POS_W-1:0]  position_count;
    logic [ITAE_W-1:0]        itae_total;

    modport source (output valid, output forward_duty, output reverse_duty,
                    output position_count, output itae_total, input ready);
    modport sink   (input valid, input forward_duty, input reverse_duty,
                    input position_count, input itae_total, output ready);
endinterface

FILE: src/qpid_cfg.sv
// Configuration register file: takes one write transfer per cycle.
// Depends on qpid_pkg and qpid_cfg_if.
module qpid_cfg import qpid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qpid_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_COEF_NOW:   n_cfg.coef_now    = i_cfg.data[COEF_W-1:0];
                REG_COEF_PREV:  n_cfg.coef_prev   = i_cfg.data[COEF_W-1:0];
                REG_COEF_PREV2: n_cfg.coef_prev2  = i_cfg.data[COEF_W-1:0];
                REG_PWM_RANGE:  n_cfg.pwm_range   = i_cfg.data[DUTY_W-1:0];
                REG_PERIOD:     n_cfg.loop_period = i_cfg.data[PERIOD_W-1:0];
                REG_GEAR_SCALE: n_cfg.gear_scale  = i_cfg.data[SCALE_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_now    <= RST_COEF_NOW;
            r_cfg.coef_prev   <= RST_COEF_PREV;
            r_cfg.coef_prev2  <= RST_COEF_PREV2;
            r_cfg.pwm_range   <= RST_PWM_RANGE;
            r_cfg.loop_period <= RST_PERIOD;
            r_cfg.gear_scale  <= RST_GEAR_SCALE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: src/qpid_quad.sv
// Saturating quadrature counter stepped by encoder edge events.
// Depends on qpid_pkg.
module qpid_quad import qpid_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_edge                        i_edge,
    output logic signed [COUNT_BITS-1:0] o_count
);

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic signed [COUNT_BITS-1:0] r_count;
    logic signed [COUNT_BITS-1:0] n_count;
    logic                         w_up;

    assign w_up    = i_edge.sel_b ? (i_edge.chan_a == i_edge.chan_b)
                                  : (i_edge.chan_a != i_edge.chan_b);
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_edge.en) begin
            if (w_up && (r_count != CNT_MAX)) begin
                n_count = r_count + COUNT_BITS'(1);
            end else if (!w_up && (r_count != CNT_MIN)) begin
                n_count = r_count - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: src/qpid_mul.sv
// Shared signed multiplier with a registered product.
// Depends on qpid_pkg.
module qpid_mul import qpid_pkg::*; (
    input  logic                       i_clk,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output logic signed [MUL_P_W-1:0]  o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

endmodule

FILE: src/quadrature_pid_position_controller_top.sv
// Quadrature PID position controller: top level with the tick sequencer.
// Depends on qpid_pkg, qpid_if, qpid_cfg, qpid_quad and qpid_mul.
//
// Channels: i_cfg takes register writes (index, data) and is always ready.
// i_cmd takes items: encoder edge on A or B, control tick, or trial start.
// o_res returns one result per item: both duties, the count and the ITAE sum.
// An item is taken only in the idle state; the block works on one at a time.
// Edge and trial-start items go from the idle state straight to the last step.
// A control tick passes through the multiply states: its six products go one after
// another through the single registered multiplier (count times gear scale,
// three PID weights, elapsed times period, then times the error magnitude).
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds a finished item in the last step
// until the output register frees.
// Reset (synchronous, active low) loads the register defaults and clears the
// count, drive, error history, duties and ITAE sum; no result is pending.
module quadrature_pid_position_controller_top import qpid_pkg::*; #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qpid_cfg_if.sink    i_cfg,
    qpid_in_if.sink     i_cmd,
    qpid_out_if.source  o_res
);

    localparam int GL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int GR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int EW = MUL_P_W + 10;
    localparam logic signed [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    t_cfg                          w_cfg;
    t_edge                         w_edge;
    t_opcode                       w_op;
    logic                          w_accept;
    logic signed [COUNT_BITS-1:0]  w_count;
    logic signed [31:0]            w_count32;

    logic signed [MUL_A_W-1:0]     w_mul_a;
    logic signed [MUL_B_W-1:0]     w_mul_b;
    logic signed [MUL_P_W-1:0]     w_prod;

    logic signed [EW-1:0]          w_prod_ext;
    logic signed [EW-1:0]          w_gear;
    logic signed [EW-1:0]          w_tgt;
    logic signed [EW-1:0]          w_diff;
    logic                          w_err_ovf;
    logic signed [ERR_W-1:0]       w_err;
    logic                          w_drive_ovf;
    logic signed [DRIVE_W-1:0]     w_drive_sat;
    logic signed [DRIVE_W-1:0]     w_duty_int;
    logic [DUTY_W-1:0]             w_duty;
    logic                          w_err_pos;
    logic [MUL_A_W-1:0]            w_mag;
    logic [ADD_W:0]                w_itae_sum;
    logic [ITAE_W-1:0]             w_itae_sat;

    t_state                        r_state;
    t_state                        n_state;
    logic signed [TARGET_W-1:0]    r_target;
    logic signed [TARGET_W-1:0]    n_target;
    logic [ELAPSED_W-1:0]          r_elapsed;
    logic [ELAPSED_W-1:0]          n_elapsed;
    logic signed [ERR_W-1:0]       r_err;
    logic signed [ERR_W-1:0]       n_err;
    logic signed [ERR_W-1:0]       r_err_last;
    logic signed [ERR_W-1:0]       n_err_last;
    logic signed [ERR_W-1:0]       r_err_older;
    logic signed [ERR_W-1:0]       n_err_older;
    logic signed [DRIVE_W-1:0]     r_drive;
    logic signed [DRIVE_W-1:0]     n_drive;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;
    logic [EP_W-1:0]               r_ep;
    logic [EP_W-1:0]               n_ep;
    logic [ITAE_W-1:0]             r_itae;
    logic [ITAE_W-1:0]             n_itae;
    logic [DUTY_W-1:0]             r_duty_fwd;
    logic [DUTY_W-1:0]             n_duty_fwd;
    logic [DUTY_W-1:0]             r_duty_rev;
    logic [DUTY_W-1:0]             n_duty_rev;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [DUTY_W-1:0]             r_out_fwd;
    logic [DUTY_W-1:0]             n_out_fwd;
    logic [DUTY_W-1:0]             r_out_rev;
    logic [DUTY_W-1:0]             n_out_rev;
    logic signed [POS_W-1:0]       r_out_pos;
    logic signed [POS_W-1:0]       n_out_pos;
    logic [ITAE_W-1:0]             r_out_itae;
    logic [ITAE_W-1:0]             n_out_itae;

    qpid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    qpid_quad #(
        .COUNT_BITS (COUNT_BITS)
    ) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (w_edge),
        .o_count (w_count)
    );

    qpid_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_op         = t_opcode'(i_cmd.opcode);
    assign i_cmd.ready  = (r_state == S_IDLE);
    assign w_accept     = i_cmd.valid && i_cmd.ready;
    assign w_edge.en    = w_accept && ((w_op == OP_EDGE_A) || (w_op == OP_EDGE_B));
    assign w_edge.sel_b = (w_op == OP_EDGE_B);
    assign w_edge.chan_a = i_cmd.chan_a;
    assign w_edge.chan_b = i_cmd.chan_b;
    assign w_count32    = 32'(w_count);

    // error: target in Q.FRAC minus scaled count, saturated to the error width
    assign w_prod_ext = EW'(w_prod);
    assign w_gear     = (w_prod_ext <<< GL) >>> GR;
    assign w_tgt      = EW'(r_target) <<< FRAC_BITS;
    assign w_diff     = w_tgt - w_gear;
    assign w_err_ovf  = !(&w_diff[EW-1:ERR_W-1]) && (|w_diff[EW-1:ERR_W-1]);
    assign w_err      = w_err_ovf ? (w_diff[EW-1] ? ERR_MIN : ERR_MAX)
                                  : $signed(w_diff[ERR_W-1:0]);

    // drive: saturate the velocity-form sum, take the floor integer part, clamp
    assign w_drive_ovf = !(&r_acc[ACC_W-1:DRIVE_W-1]) && (|r_acc[ACC_W-1:DRIVE_W-1]);
    assign w_drive_sat = w_drive_ovf ? (r_acc[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX)
                                     : $signed(r_acc[DRIVE_W-1:0]);
    assign w_duty_int  = w_drive_sat >>> FRAC_BITS;

    always_comb begin
        if (w_duty_int[DRIVE_W-1]) begin
            w_duty = '0;
        end else if (w_duty_int > $signed({{(DRIVE_W-DUTY_W){1'b0}}, w_cfg.pwm_range})) begin
            w_duty = w_cfg.pwm_range;
        end else begin
            w_duty = w_duty_int[DUTY_W-1:0];
        end
    end

    assign w_err_pos  = !r_err[ERR_W-1] && (r_err != '0);
    assign w_mag      = r_err[ERR_W-1] ? (-MUL_A_W'(r_err)) : MUL_A_W'(r_err);
    assign w_itae_sum = (ADD_W+1)'(r_itae) + {1'b0, w_prod[ADD_W-1:0]};
    assign w_itae_sat = (|w_itae_sum[ADD_W:ITAE_W]) ? {ITAE_W{1'b1}}
                                                    : w_itae_sum[ITAE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_elapsed   = r_elapsed;
        n_err       = r_err;
        n_err_last  = r_err_last;
        n_err_older = r_err_older;
        n_drive     = r_drive;
        n_acc       = r_acc;
        n_ep        = r_ep;
        n_itae      = r_itae;
        n_duty_fwd  = r_duty_fwd;
        n_duty_rev  = r_duty_rev;
        n_out_valid = r_out_valid;
        n_out_fwd   = r_out_fwd;
        n_out_rev   = r_out_rev;
        n_out_pos   = r_out_pos;
        n_out_itae  = r_out_itae;
        w_mul_a     = '0;
        w_mul_b     = '0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_target  = i_cmd.target_position;
                    n_elapsed = i_cmd.elapsed_ms;
                    case (w_op)
                        OP_TICK: begin
                            n_state = S_MUL_POS;
                        end
                        OP_START: begin
                            n_drive     = '0;
                            n_err_last  = '0;
                            n_err_older = '0;
                            n_state     = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL_POS: begin
                w_mul_a = MUL_A_W'(w_count);
                w_mul_b = MUL_B_W'(w_cfg.gear_scale);
                n_state = S_ERR;
            end
            S_ERR: begin
                n_err   = w_err;
                n_state = S_MUL_NOW;
            end
            S_MUL_NOW: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(w_cfg.coef_now);
                n_state = S_MUL_PREV;
            end
            S_MUL_PREV: begin
                w_mul_a = MUL_A_W'(r_err_last);
                w_mul_b = MUL_B_W'(w_cfg.coef_prev);
                n_acc   = ACC_W'(r_drive) + $signed(w_prod[ACC_W-1:0]);
                n_state = S_MUL_PREV2;
            end
            S_MUL_PREV2: begin
                w_mul_a = MUL_A_W'(r_err_older);
                w_mul_b = MUL_B_W'(w_cfg.coef_prev2);
                n_acc   = r_acc - $signed(w_prod[ACC_W-1:0]);
                n_state = S_MUL_EP;
            end
            S_MUL_EP: begin
                w_mul_a = MUL_A_W'(r_elapsed);
                w_mul_b = MUL_B_W'(w_cfg.loop_period);
                n_acc   = r_acc + $signed(w_prod[ACC_W-1:0]);
                n_state = S_DRIVE;
            end
            S_DRIVE: begin
                n_ep        = w_prod[EP_W-1:0];
                n_drive     = w_drive_sat;
                n_err_older = r_err_last;
                n_err_last  = r_err;
                if (w_err_pos) begin
                    n_duty_fwd = w_duty;
                    n_duty_rev = '0;
                end else begin
                    n_duty_fwd = '0;
                    n_duty_rev = w_duty;
                end
                n_state = S_MUL_ITAE;
            end
            S_MUL_ITAE: begin
                w_mul_a = w_mag;
                w_mul_b = MUL_B_W'(r_ep);
                n_state = S_ITAE;
            end
            S_ITAE: begin
                n_itae  = w_itae_sat;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_fwd   = r_duty_fwd;
                    n_out_rev   = r_duty_rev;
                    n_out_pos   = w_count32[POS_W-1:0];
                    n_out_itae  = r_itae;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_err_last  <= '0;
            r_err_older <= '0;
            r_drive     <= '0;
            r_itae      <= '0;
            r_duty_fwd  <= '0;
            r_duty_rev  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_err_last  <= n_err_last;
            r_err_older <= n_err_older;
            r_drive     <= n_drive;
            r_itae      <= n_itae;
            r_duty_fwd  <= n_duty_fwd;
            r_duty_rev  <= n_duty_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target   <= n_target;
        r_elapsed  <= n_elapsed;
        r_err      <= n_err;
        r_acc      <= n_acc;
        r_ep       <= n_ep;
        r_out_fwd  <= n_out_fwd;
        r_out_rev  <= n_out_rev;
        r_out_pos  <= n_out_pos;
        r_out_itae <= n_out_itae;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.forward_duty   = r_out_fwd;
    assign o_res.reverse_duty   = r_out_rev;
    assign o_res.position_count = r_out_pos;
    assign o_res.itae_total     = r_out_itae;

    a_duty_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_duty_fwd != '0) && (r_duty_rev != '0)))
        else $error("both duties driven");

    a_itae_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITAE) |=> (r_itae >= $past(r_itae)))
        else $error("ITAE sum decreased");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_TICK)) |=> !i_cmd.ready)
        else $error("item taken during a tick");

    a_count_only_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_edge.en |=> $stable(w_count))
        else $error("count moved without an edge transfer");

endmodule
